// File: rtl/swmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_pkg: shared types and constants for the sliding window statistics block
// Field widths, window limits and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package swmv_pkg;

	// window geometry
	localparam int WINDOW_MAX = 64;
	localparam int RING_AW    = $clog2(WINDOW_MAX);

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int LEN_W    = 7;
	localparam int VAR_W    = 48;

	// running sums and the division datapath
	localparam int SUM_W     = 30;
	localparam int SQ_W      = 54;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int NUM_W     = 2 * SUM_W;
	localparam int DEN_W     = 2 * LEN_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// window length register limits
	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WINDOW_MAX);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic square_old;
		logic accumulate;
		logic multiply;
		logic load_div;
		logic div_step;
		logic load_out;
	} swmv_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_last;
	} swmv_status_t;

endpackage
`default_nettype wire

// File: rtl/swmv_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_in_if: sample channel
// Valid/ready channel carrying one signed Q12.12 sample per item.
// ----------------------------------------------------------------------------
interface swmv_in_if
	import swmv_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: rtl/swmv_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_out_if: result channel
// Valid/ready channel carrying mean, variance and window fill per item.
// ----------------------------------------------------------------------------
interface swmv_out_if
	import swmv_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mean;
	logic        [VAR_W-1:0]    variance;
	logic        [LEN_W-1:0]    samples_in_window;

	modport source (output valid, output mean, output variance,
		output samples_in_window, input ready);
	modport sink   (input valid, input mean, input variance,
		input samples_in_window, output ready);
endinterface
`default_nettype wire

// File: rtl/swmv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_datapath: sample ring, running sums and dual restoring divider
// Keeps the window in a ring memory, updates exact sum and sum of squares,
// forms the variance numerator and divides mean and variance one bit a cycle.
// ----------------------------------------------------------------------------
module swmv_datapath
	import swmv_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire        [LEN_W-1:0]     cfg_wdata,
	input  wire signed [SAMPLE_W-1:0]  sample,
	input  swmv_cmd_t                  cmd,
	output swmv_status_t               status,
	output logic signed [SAMPLE_W-1:0] mean,
	output logic        [VAR_W-1:0]    variance,
	output logic        [LEN_W-1:0]    samples_in_window
);

	// window control state
	logic [LEN_W-1:0]   len_q;
	logic [RING_AW-1:0] slot_q;
	logic [LEN_W-1:0]   fill_q;
	logic               evict_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]    sq_q;

	// per item working registers
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] old_rd_q;
	logic [PROD_W-1:0]  new_sq_q;
	logic [PROD_W-1:0]  old_sq_q;
	logic [NUM_W-1:0]   nsq_q;
	logic [NUM_W-1:0]   sumsq_q;
	logic [DEN_W-1:0]   den_q;
	logic [SUM_W-1:0]   mag_q;
	logic               neg_q;

	// divider registers
	logic [NUM_W-1:0]   var_quo_q;
	logic [DEN_W-1:0]   var_rem_q;
	logic [NUM_W-1:0]   mean_quo_q;
	logic [LEN_W-1:0]   mean_rem_q;
	logic [CNT_W-1:0]   cnt_q;

	// result register
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]   var_q;
	logic [LEN_W-1:0]   n_q;

	// sample ring
	logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];

	logic [RING_AW-1:0]       old_slot;
	logic [LEN_W-1:0]         len_clamped;
	logic signed [PROD_W-1:0] prod_new;
	logic signed [PROD_W-1:0] prod_old;
	logic [SUM_W-1:0]         mag;
	logic [LEN_W+SQ_W-1:0]    nsq_full;
	logic [NUM_W-1:0]         sumsq_full;
	logic [DEN_W-1:0]         den_full;
	logic [DEN_W:0]           var_sh;
	logic                     var_ge;
	logic [LEN_W:0]           mean_sh;
	logic                     mean_ge;
	logic [SAMPLE_W-1:0]      mean_mag;

	// slot that leaves the window once it is full
	assign old_slot = slot_q - RING_AW'(len_q);

	// raise or lower the written window length into range
	always_comb begin
		if (cfg_wdata < LEN_MIN) begin
			len_clamped = LEN_MIN;
		end else if (cfg_wdata > LEN_MAX) begin
			len_clamped = LEN_MAX;
		end else begin
			len_clamped = cfg_wdata;
		end
	end

	// squares and variance numerator products
	assign prod_new   = sample * sample;
	assign prod_old   = old_rd_q * old_rd_q;
	assign mag        = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign nsq_full   = (LEN_W+SQ_W)'(fill_q) * (LEN_W+SQ_W)'(sq_q);
	assign sumsq_full = NUM_W'(mag) * NUM_W'(mag);
	assign den_full   = DEN_W'(fill_q) * DEN_W'(fill_q - LEN_W'(1));

	// one restoring step for each quotient
	assign var_sh   = {var_rem_q, var_quo_q[NUM_W-1]};
	assign var_ge   = var_sh >= {1'b0, den_q};
	assign mean_sh  = {mean_rem_q, mean_quo_q[NUM_W-1]};
	assign mean_ge  = mean_sh >= {1'b0, fill_q};
	assign mean_mag = mean_quo_q[SAMPLE_W-1:0];

	// write the new sample, read the one that drops out
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[slot_q] <= sample;
			old_rd_q         <= ring_mem[old_slot];
		end
	end

	// window control: length register, write slot, fill and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			slot_q  <= '0;
			fill_q  <= '0;
			evict_q <= 1'b0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cfg_we) begin
			len_q   <= len_clamped;
			slot_q  <= '0;
			fill_q  <= '0;
			evict_q <= 1'b0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else begin
			if (cmd.accept) begin
				evict_q <= (fill_q == len_q);
				if (fill_q != len_q) begin
					fill_q <= fill_q + LEN_W'(1);
				end
				slot_q <= slot_q + RING_AW'(1);
			end
			if (cmd.accumulate) begin
				sum_q <= sum_q + SUM_W'(sample_q)
					- (evict_q ? SUM_W'(old_rd_q) : SUM_W'(0));
				sq_q  <= sq_q + SQ_W'(new_sq_q)
					- (evict_q ? SQ_W'(old_sq_q) : SQ_W'(0));
			end
		end
	end

	// per item arithmetic and division
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			new_sq_q <= $unsigned(prod_new);
		end
		if (cmd.square_old) begin
			old_sq_q <= $unsigned(prod_old);
		end
		if (cmd.multiply) begin
			nsq_q   <= nsq_full[NUM_W-1:0];
			sumsq_q <= sumsq_full;
			den_q   <= den_full;
			mag_q   <= mag;
			neg_q   <= sum_q[SUM_W-1];
		end
		if (cmd.load_div) begin
			var_quo_q  <= nsq_q - sumsq_q;
			var_rem_q  <= '0;
			mean_quo_q <= NUM_W'(mag_q);
			mean_rem_q <= '0;
		end
		if (cmd.div_step) begin
			var_rem_q  <= var_ge ? DEN_W'(var_sh - {1'b0, den_q}) : DEN_W'(var_sh);
			var_quo_q  <= {var_quo_q[NUM_W-2:0], var_ge};
			mean_rem_q <= mean_ge ? LEN_W'(mean_sh - {1'b0, fill_q}) : LEN_W'(mean_sh);
			mean_quo_q <= {mean_quo_q[NUM_W-2:0], mean_ge};
		end
		if (cmd.load_out) begin
			mean_q <= neg_q ? $signed(-mean_mag) : $signed(mean_mag);
			if (fill_q < LEN_MIN) begin
				var_q <= '0;
			end else if (|var_quo_q[NUM_W-1:VAR_W]) begin
				var_q <= '1;
			end else begin
				var_q <= var_quo_q[VAR_W-1:0];
			end
			n_q <= fill_q;
		end
	end

	// division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_div) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign status.div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign mean              = mean_q;
	assign variance          = var_q;
	assign samples_in_window = n_q;

`ifndef NO_ASSERTIONS
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count exceeds window length");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q >= LEN_MIN) && (len_q <= LEN_MAX))
		else $error("window length out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/swmv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_ctrl: sequencer for one item
// Steps the datapath through ring access, sum update, products and the
// bit-serial division, then hands the result to the output register.
// ----------------------------------------------------------------------------
module swmv_ctrl
	import swmv_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire          out_ready,
	output swmv_cmd_t    cmd,
	input  swmv_status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQR,
		S_ACC,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && in_valid;
		cmd.square_old = (state_q == S_SQR);
		cmd.accumulate = (state_q == S_ACC);
		cmd.multiply   = (state_q == S_MUL);
		cmd.load_div   = (state_q == S_LOAD);
		cmd.div_step   = (state_q == S_DIV);
		cmd.load_out   = (state_q == S_DONE) && out_free;
	end

	// advance through the item and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQR;
					end
				end
				S_SQR:  state_q <= S_ACC;
				S_ACC:  state_q <= S_MUL;
				S_MUL:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (status.div_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item taken while one is in progress");
`endif

endmodule
`default_nettype wire

// File: rtl/sliding_window_mean_variance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_mean_variance: windowed mean and sample variance
// Mean and n-1 variance over the most recent samples, with exact sums.
// ----------------------------------------------------------------------------
// Usage:
//   samples: valid/ready channel, one signed Q12.12 sample per item.
//   results: valid/ready channel, one item per sample: mean (Q12.12, truncated
//     toward zero), variance (Q24.24, saturating, zero for a single sample)
//     and the number of samples covered.
//   cfg_we/cfg_wdata: window length, clamped to 2..64; a write restarts the
//     statistics. Write only while no item is in progress.
// Timing: an item is taken while the block is idle, then ring read, sum update, products
//   and a 60-step bit-serial divider (one quotient bit per cycle for mean and
//   variance in parallel) follow; the result is then registered for output.
//   A new sample is taken only once the previous one has left the divider.
// The result register lets a new sample be taken while a result waits; if the
//   receiver stalls longer, the next result is held until the register frees.
// Reset: window length 8, window empty, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance
	import swmv_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [LEN_W-1:0]  cfg_wdata,
	swmv_in_if.sink          samples,
	swmv_out_if.source       results
);

	swmv_cmd_t    cmd;
	swmv_status_t status;

	// sequencer
	swmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// ring, sums and divider
	swmv_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.sample            (samples.sample),
		.cmd               (cmd),
		.status            (status),
		.mean              (results.mean),
		.variance          (results.variance),
		.samples_in_window (results.samples_in_window)
	);

endmodule
`default_nettype wire
